// ===== rtl/esa_pkg.sv =====
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types and constants for the entity slot allocator: opcodes, status
// codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package esa_pkg;

    // default table geometry
    localparam int ESA_CAPACITY  = 256;
    localparam int ESA_WORD_BITS = 32;

    // fixed port widths
    localparam int OPCODE_W = 3;
    localparam int SLOT_W   = 8;
    localparam int COMP_W   = 5;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // bit position of a component inside an entity word (component + 1)
    localparam int POS_W = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_ALIVE   = 3'd2,
        OP_HAS     = 3'd3,
        OP_ADD     = 3'd4,
        OP_REMOVE  = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== rtl/esa_word_ram.sv =====
// ----------------------------------------------------------------------------
// esa_word_ram
// Simple dual-port synchronous RAM holding the entity words: one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module esa_word_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/entity_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// entity_slot_allocator_core
// Entity table with next-fit slot allocation and per-entity component flags.
//
//   channel   | handshake              | fields
//   ----------+------------------------+-----------------------------------
//   command   | start / busy           | opcode, slot, component
//   result    | done (1-cycle strobe)  | given_slot, answer_flag,
//             |                        | live_count, status
//
// A command transfers when start is high and busy is low. Every command
// except create does one memory read, then modify and write back. Create
// probes one table word per cycle from the rover, up to every word of the
// table; the single read port of the word RAM sets this rate. After reset
// a clearing pass writes zero to every word with busy high. The result
// strobe cannot be stalled; it is shown in the cycle in which the next
// command may already transfer.
// ----------------------------------------------------------------------------
module entity_slot_allocator_core #(
    parameter int CAPACITY  = esa_pkg::ESA_CAPACITY,
    parameter int WORD_BITS = esa_pkg::ESA_WORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [esa_pkg::OPCODE_W-1:0] opcode,
    input  logic [esa_pkg::SLOT_W-1:0]   slot,
    input  logic [esa_pkg::COMP_W-1:0]   component,
    output logic                         done,
    output logic [esa_pkg::SLOT_W-1:0]   given_slot,
    output logic                         answer_flag,
    output logic [esa_pkg::COUNT_W-1:0]  live_count,
    output logic [esa_pkg::STATUS_W-1:0] status
);

    import esa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    // controller state
    state_t         state_reg, state_next;
    logic [AW-1:0]  rover_reg, rover_next;
    logic [AW-1:0]  probe_reg, probe_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [CW-1:0]  alive_reg, alive_next;
    logic           done_reg, done_next;

    // result payload
    logic [SLOT_W-1:0] given_reg, given_next;
    logic              answer_reg, answer_next;
    status_t           status_reg, status_next;

    // command payload
    opcode_t        op_reg;
    logic [AW-1:0]  addr_reg;
    logic           in_range_reg;
    logic [POS_W-1:0] pos_reg;

    // memory ports
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // decode helpers
    logic [XW-1:0]        slot_ext;
    logic [AW-1:0]        slot_addr;
    logic                 slot_in_range;
    logic                 accept;
    logic [AW-1:0]        rover_inc;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] bit_mask;

    esa_word_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // command decode
    assign slot_ext      = XW'(slot);
    assign slot_addr     = slot_ext[AW-1:0];
    assign slot_in_range = 32'(slot) < 32'(CAPACITY);
    assign accept        = start && (state_reg == ST_IDLE);
    assign rover_inc     = (rover_reg == LAST_ADDR) ? '0 : rover_reg + 1'b1;

    // out-of-range slots read as an empty word
    assign word = in_range_reg ? rd_data : '0;

    // one-hot component bit, none when the position falls outside the word
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            bit_mask[i] = (POS_W'(i) == pos_reg);
        end
    end

    // command payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= opcode_t'(opcode);
            addr_reg     <= slot_addr;
            in_range_reg <= slot_in_range;
            pos_reg      <= POS_W'(component) + 1'b1;
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            rover_reg  <= '0;
            probe_reg  <= '0;
            clr_reg    <= '0;
            alive_reg  <= '0;
            done_reg   <= 1'b0;
            given_reg  <= '0;
            answer_reg <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            rover_reg  <= rover_next;
            probe_reg  <= probe_next;
            clr_reg    <= clr_next;
            alive_reg  <= alive_next;
            done_reg   <= done_next;
            given_reg  <= given_next;
            answer_reg <= answer_next;
            status_reg <= status_next;
        end
    end

    // next state, memory access and result
    always_comb
    begin
        state_next  = state_reg;
        rover_next  = rover_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        alive_next  = alive_reg;
        done_next   = 1'b0;
        given_next  = given_reg;
        answer_next = answer_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = rover_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_data     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one word per cycle
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = (opcode == OP_CREATE) ? rover_reg : slot_addr;
                    probe_next = '0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // by default the result goes out after this cycle
                done_next   = 1'b1;
                state_next  = ST_IDLE;
                given_next  = '0;
                answer_next = 1'b0;
                status_next = STAT_OK;

                unique case (op_reg)
                    OP_CREATE:
                    begin
                        priority if (alive_reg >= CW'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (rd_data == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = rover_reg;
                            wr_data    = WORD_BITS'(1);
                            alive_next = alive_reg + 1'b1;
                            given_next = SLOT_W'(rover_reg);
                        end
                        else
                        begin
                            // occupied: step the rover and probe again
                            rover_next = rover_inc;
                            if (probe_reg == LAST_ADDR)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_EXEC;
                                probe_next = probe_reg + 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = rover_inc;
                            end
                        end
                    end

                    OP_DESTROY:
                    begin
                        if (word == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (alive_reg != '0)
                            begin
                                alive_next = alive_reg - 1'b1;
                            end
                        end
                    end

                    OP_ALIVE:
                    begin
                        answer_next = (word != '0);
                    end

                    OP_HAS:
                    begin
                        answer_next = |(word & bit_mask);
                    end

                    OP_ADD:
                    begin
                        wr_en   = in_range_reg;
                        wr_data = word | bit_mask;
                    end

                    OP_REMOVE:
                    begin
                        wr_en   = in_range_reg;
                        wr_data = word & ~bit_mask;
                    end

                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign given_slot  = given_reg;
    assign answer_flag = answer_reg;
    assign live_count  = COUNT_W'(alive_reg);
    assign status      = status_reg;

`ifndef SYNTHESIS
    // a transferred command always goes to the execute state
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted command did not enter execute");

    // results are never shown in two consecutive cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    // a failed create hands out no slot
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STAT_FULL)) |-> (given_reg == '0))
        else $error("full status with nonzero slot");

    // the live count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alive_reg <= CW'(CAPACITY))
        else $error("live count above capacity");

    // a result only follows the execute state
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_EXEC))
        else $error("result strobe without execute");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the entity slot allocator. Commands are queued up
// front: a directed opening, then random phases that mix operations, fill
// the table to full, defeat the search with uncounted words and churn the
// table. A clocked driver transfers them over start / busy with random gaps.
// A clocked monitor checks every done strobe, field by field, against the
// oldest result predicted by the bench's own model of the table.
// ----------------------------------------------------------------------------
module tb_top;

    import esa_pkg::*;

    localparam int TABLE_DEPTH  = ESA_CAPACITY;
    localparam int WORD_W       = ESA_WORD_BITS;
    localparam int RESET_CYCLES = 6;
    localparam int QUIET_TAIL   = 100;
    localparam int MAX_CMDS     = 4096;
    localparam int SETTLE_LIMIT = 4 * TABLE_DEPTH + 100;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // one queued command
    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [SLOT_W-1:0]   slot;
        logic [COMP_W-1:0]   comp;
        bit                  hold_for_drain;
    } cmd_t;

    // one predicted result
    typedef struct packed {
        logic [SLOT_W-1:0]  given_slot;
        logic               answer;
        logic [COUNT_W-1:0] live;
        status_t            st;
    } alloc_result_t;

    // random phase flavors
    typedef enum int {
        MIX_ANY,
        MIX_FILL,
        MIX_CHURN
    } mix_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic [OPCODE_W-1:0] opcode    = '0;
    logic [SLOT_W-1:0]   slot      = '0;
    logic [COMP_W-1:0]   component = '0;
    logic                busy;
    logic                done;
    logic [SLOT_W-1:0]   given_slot;
    logic                answer_flag;
    logic [COUNT_W-1:0]  live_count;
    logic [STATUS_W-1:0] status;

    // model of the table
    logic [WORD_W-1:0] table_words [TABLE_DEPTH];
    int unsigned       rover_pos;
    int unsigned       live_total;

    // command stream and predicted results
    cmd_t          pending_cmds[$];
    alloc_result_t expected_results [MAX_CMDS];
    alloc_result_t next_result;
    alloc_result_t want;
    int            issued      = 0;
    int            retired     = 0;
    int            sent_count  = 0;
    int            gap_left    = 0;
    int            error_count = 0;

    entity_slot_allocator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .slot        (slot),
        .component   (component),
        .done        (done),
        .given_slot  (given_slot),
        .answer_flag (answer_flag),
        .live_count  (live_count),
        .status      (status)
    );

    // clock
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // apply one command to the table model and return its result
    function automatic alloc_result_t apply_command(input cmd_t c);
        alloc_result_t     r;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] bit_sel;
        int unsigned       pos;
        bit                in_range;
        bit                found;
        int                p;
        r        = '0;
        r.st     = STAT_OK;
        in_range = c.slot < TABLE_DEPTH;
        word     = in_range ? table_words[c.slot] : '0;
        pos      = c.comp + 1;
        bit_sel  = '0;
        if (pos < WORD_W)
            bit_sel[pos] = 1'b1;
        case (c.op)
            OP_CREATE:
            begin
                if (live_total >= TABLE_DEPTH)
                    r.st = STAT_FULL;
                else
                begin
                    // next-fit search from the rover, rover stops on the hit
                    rover_pos = rover_pos % TABLE_DEPTH;
                    found     = 1'b0;
                    for (p = 0; p < TABLE_DEPTH && !found; p++)
                    begin
                        if (table_words[rover_pos] == '0)
                            found = 1'b1;
                        else
                            rover_pos = (rover_pos + 1) % TABLE_DEPTH;
                    end
                    if (!found)
                        r.st = STAT_FULL;
                    else
                    begin
                        table_words[rover_pos] = 1;
                        live_total++;
                        r.given_slot = SLOT_W'(rover_pos);
                    end
                end
            end
            OP_DESTROY:
            begin
                if (word == '0)
                    r.st = STAT_EMPTY;
                else
                begin
                    table_words[c.slot] = '0;
                    // count saturates at zero for uncounted words
                    if (live_total > 0)
                        live_total--;
                end
            end
            OP_ALIVE:
                r.answer = word != '0;
            OP_HAS:
                r.answer = (word & bit_sel) != '0;
            OP_ADD:
            begin
                if (in_range)
                    table_words[c.slot] = word | bit_sel;
            end
            OP_REMOVE:
            begin
                if (in_range)
                    table_words[c.slot] = word & ~bit_sel;
            end
            default:
            begin
            end
        endcase
        r.live = COUNT_W'(live_total);
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [OPCODE_W-1:0] op,
                                      input int s, input int cp, input bit hold);
        cmd_t c;
        c.op             = op;
        c.slot           = SLOT_W'(s);
        c.comp           = COMP_W'(cp);
        c.hold_for_drain = hold;
        return c;
    endfunction

    // random command with a phase-dependent opcode mix
    function automatic cmd_t rand_cmd(input mix_t mix);
        cmd_t c;
        int   r;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL)
            r = (r < 85) ? 0 : $urandom_range(0, 99);
        else if (mix == MIX_CHURN)
            r = (r < 40) ? 25 : ((r < 60) ? 70 : $urandom_range(0, 99));
        if (r < 20)
            c.op = OP_CREATE;
        else if (r < 35)
            c.op = OP_DESTROY;
        else if (r < 50)
            c.op = OP_ALIVE;
        else if (r < 65)
            c.op = OP_HAS;
        else if (r < 80)
            c.op = OP_ADD;
        else if (r < 95)
            c.op = OP_REMOVE;
        else
            c.op = OPCODE_W'($urandom_range(6, 7));
        // low slots are where creates land first
        if ($urandom_range(0, 1) == 0)
            c.slot = SLOT_W'($urandom_range(0, 31));
        else
            c.slot = SLOT_W'($urandom_range(0, 255));
        c.comp           = COMP_W'($urandom_range(0, 31));
        c.hold_for_drain = ($urandom_range(0, 99) == 0);
        return c;
    endfunction

    // driver: one transfer per start && !busy edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                next_result = apply_command(pending_cmds[0]);
                expected_results[sent_count] <= next_result;
                sent_count++;
                issued <= sent_count;
                pending_cmds.delete(0);
            end
            // pick the next command unless one is still waiting on busy
            if (!(start && busy))
            begin
                if (gap_left > 0 || pending_cmds.size() == 0 ||
                    (pending_cmds[0].hold_for_drain && sent_count != retired))
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start     <= 1'b0;
                    opcode    <= OPCODE_W'($urandom);
                    slot      <= SLOT_W'($urandom);
                    component <= COMP_W'($urandom);
                end
                else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    gap_left  = $urandom_range(1, 11) - 1;
                    start     <= 1'b0;
                    opcode    <= OPCODE_W'($urandom);
                    slot      <= SLOT_W'($urandom);
                    component <= COMP_W'($urandom);
                end
                else
                begin
                    start     <= 1'b1;
                    opcode    <= pending_cmds[0].op;
                    slot      <= pending_cmds[0].slot;
                    component <= pending_cmds[0].comp;
                end
            end
        end
    end

    // monitor: every done strobe retires the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (retired >= issued)
                report_mismatch("result strobe with no command outstanding");
            else
            begin
                want = expected_results[retired];
                if (given_slot !== want.given_slot)
                    report_mismatch($sformatf("result %0d given_slot %0d, want %0d",
                                              retired, given_slot, want.given_slot));
                if (answer_flag !== want.answer)
                    report_mismatch($sformatf("result %0d answer_flag %0b, want %0b",
                                              retired, answer_flag, want.answer));
                if (live_count !== want.live)
                    report_mismatch($sformatf("result %0d live_count %0d, want %0d",
                                              retired, live_count, want.live));
                if (status !== want.st)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              retired, status, want.st));
                retired <= retired + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int i;
        int k;
        int rep;
        int guard;
        int scan_slot [4];
        int scan_comp [4];

        for (i = 0; i < TABLE_DEPTH; i++)
            table_words[i] = '0;
        rover_pos  = 0;
        live_total = 0;

        // directed opening
        pending_cmds.push_back(make_cmd(OP_ALIVE, 0, 0, 1'b0));
        // uncounted word destroyed with nothing live: count stays at zero
        pending_cmds.push_back(make_cmd(OP_ADD, 200, 3, 1'b0));
        pending_cmds.push_back(make_cmd(OP_DESTROY, 200, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_DESTROY, 5, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 77, 9, 1'b0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 255, 31, 1'b0));
        pending_cmds.push_back(make_cmd(OP_HAS, 1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_ADD, 1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_HAS, 1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_ADD, 1, 30, 1'b0));
        pending_cmds.push_back(make_cmd(OP_HAS, 1, 30, 1'b0));
        // component past the top of the word
        pending_cmds.push_back(make_cmd(OP_ADD, 1, 31, 1'b0));
        pending_cmds.push_back(make_cmd(OP_HAS, 1, 31, 1'b0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_HAS, 1, 0, 1'b0));
        // component on a dead slot makes it read alive
        pending_cmds.push_back(make_cmd(OP_ADD, 255, 7, 1'b0));
        pending_cmds.push_back(make_cmd(OP_ALIVE, 255, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_DESTROY, 255, 0, 1'b0));
        // unused opcodes
        pending_cmds.push_back(make_cmd(3'd6, 255, 31, 1'b0));
        pending_cmds.push_back(make_cmd(3'd7, 0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_DESTROY, 1, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_DESTROY, 1, 0, 1'b0));
        // rover sits on a live slot and must step past it
        pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(OP_ALIVE, 3, 0, 1'b0));

        // random phases
        for (i = 0; i < 150; i++)
            pending_cmds.push_back(rand_cmd(MIX_ANY));
        pending_cmds[$].hold_for_drain = 1'b1;
        for (i = 0; i < 50; i++)
            pending_cmds.push_back(rand_cmd(MIX_FILL));
        // enough creates follow to fill the table, then a few more
        for (i = 0; i < 270; i++)
            pending_cmds.push_back(make_cmd(OP_CREATE, $urandom_range(0, 255),
                                            $urandom_range(0, 31), 1'b0));
        pending_cmds[$].hold_for_drain = 1'b1;

        // freed slots refilled by uncounted words: the search finds nothing
        for (rep = 0; rep < 2; rep++)
        begin
            for (k = 0; k < 4; k++)
            begin
                scan_slot[k] = $urandom_range(0, 255);
                scan_comp[k] = $urandom_range(0, 30);
                pending_cmds.push_back(make_cmd(OP_DESTROY, scan_slot[k], 0, 1'b0));
                pending_cmds.push_back(make_cmd(OP_ADD, scan_slot[k], scan_comp[k], 1'b0));
            end
            pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 1'b0));
            pending_cmds.push_back(make_cmd(OP_REMOVE, scan_slot[0], scan_comp[0], 1'b0));
            pending_cmds.push_back(make_cmd(OP_CREATE, 0, 0, 1'b0));
        end

        for (i = 0; i < 120; i++)
            pending_cmds.push_back(rand_cmd(MIX_CHURN));
        for (i = 0; i < 60; i++)
            pending_cmds.push_back(rand_cmd(MIX_ANY));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0)
            @(posedge clk);
        guard = 0;
        while (retired != issued && guard < SETTLE_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * TABLE_DEPTH) @(posedge clk);
        if (retired != issued)
            report_mismatch($sformatf("%0d results never arrived", issued - retired));

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== entity_slot_allocator_core.f =====
rtl/esa_pkg.sv
rtl/esa_word_ram.sv
rtl/entity_slot_allocator_core.sv
dv/tb_top.sv
